### hdl/ndpf_pkg.sv
// ndpf_pkg: shared types and constants for the neighbour d-index point filter
// no dependencies
package ndpf_pkg;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIDX_W = 12;
  localparam int unsigned CLASS_W = 8;
  localparam int unsigned BIN_W = 10;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned CFG_W = 31;
  localparam int unsigned CFG_IDX_W = 3;
  // point record: bin row, bin col, x, y, z, dindex, class
  localparam int unsigned REC_W = 2 * BIN_W + 3 * COORD_W + DIDX_W + CLASS_W;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DLOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DHIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK = 3'd4;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic [BIN_W-1:0] bin_row;
    logic [BIN_W-1:0] bin_col;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [DIDX_W-1:0] dindex;
    logic [CLASS_W-1:0] urban_class;
  } rec_t;

  typedef struct packed {
    logic loaded;
    logic unusable;
    logic killed;
  } flags_t;

  typedef struct packed {
    logic req_type;
    logic [IDX_W-1:0] point_index;
    logic [BIN_W-1:0] bin_row;
    logic [BIN_W-1:0] bin_col;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [DIDX_W-1:0] dindex;
    logic [CLASS_W-1:0] urban_class;
    logic unusable;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    logic killed;
  } rsp_t;
endpackage

### hdl/ndpf_if.sv
// ndpf_if: valid/ready channel carrying one payload
// depends on ndpf_pkg for payload types
interface ndpf_req_if;
  import ndpf_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ndpf_rsp_if;
  import ndpf_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/ndpf_ram.sv
// ndpf_ram: generic single write, single read ram with registered read
// no dependencies
module ndpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/neighbor_dindex_point_filter.sv
// neighbor_dindex_point_filter: top level, point store and neighbour scan
// depends on ndpf_pkg, ndpf_if and ndpf_ram
//
// A load transaction with an index in range writes the point record and its flags.
// A query that is a candidate scans every slot of the store through one read
// port of each ram, one slot a cycle, stopping at the first match; a query that
// is not a candidate skips the scan and goes straight to its result.
// The flag ram is cleared after reset by a pass over all MAX_POINTS slots,
// during which no request is accepted. One result transaction follows each query.
module neighbor_dindex_point_filter
  import ndpf_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  ndpf_req_if.sink req,
  ndpf_rsp_if.source rsp
);
  localparam int unsigned AW = $clog2(MAX_POINTS);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_CRD   = 7'b0000100,
    S_CCHK  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_KILL  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [CFG_W-1:0] search_radius, slab_height;
  logic [DIDX_W-1:0] dindex_low_cutoff, dindex_high_cutoff;
  logic [CLASS_W-1:0] urban_mask;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      search_radius <= CFG_W'(1000);
      slab_height <= CFG_W'(2000);
      dindex_low_cutoff <= '0;
      dindex_high_cutoff <= '1;
      urban_mask <= CLASS_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS: search_radius <= cfg_data;
        REG_HEIGHT: slab_height <= cfg_data;
        REG_DLOW: dindex_low_cutoff <= cfg_data[DIDX_W-1:0];
        REG_DHIGH: dindex_high_cutoff <= cfg_data[DIDX_W-1:0];
        REG_MASK: urban_mask <= cfg_data[CLASS_W-1:0];
        default: ;
      endcase
    end
  end

  // ram ports
  logic rec_we, flg_we;
  logic [AW-1:0] rec_waddr, flg_waddr, raddr;
  rec_t rec_wdata, rec_rdata;
  flags_t flg_wdata, flg_rdata;

  ndpf_ram #(.WIDTH(REC_W), .DEPTH(MAX_POINTS)) u_rec (
    .clk, .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr, .rdata(rec_rdata)
  );
  ndpf_ram #(.WIDTH(3), .DEPTH(MAX_POINTS)) u_flg (
    .clk, .we(flg_we), .waddr(flg_waddr), .wdata(flg_wdata),
    .raddr, .rdata(flg_rdata)
  );

  logic [AW:0] cnt;          // clear pointer and scan issue pointer
  logic [AW:0] cmp_n;        // slot whose data is on the read port
  logic cmp_v;
  logic [IDX_W-1:0] q_idx;
  rec_t cand;
  logic hit;

  logic in_range;
  assign in_range = (32'(req.data.point_index) < 32'(MAX_POINTS));

  assign req.ready = (state == S_IDLE) && !rsp.valid;

  // neighbour test stage 1: differences, registered
  logic [COORD_W:0] adx, ady, adz;
  logic adj_ok, flg_ok, cls_ok, di_ok, s1_v;
  logic [BIN_W:0] dr, dc;
  logic signed [COORD_W:0] ddx, ddy, ddz;
  always_comb begin
    ddx = $signed({cand.pos_x[COORD_W-1], cand.pos_x})
          - $signed({rec_rdata.pos_x[COORD_W-1], rec_rdata.pos_x});
    ddy = $signed({cand.pos_y[COORD_W-1], cand.pos_y})
          - $signed({rec_rdata.pos_y[COORD_W-1], rec_rdata.pos_y});
    ddz = $signed({cand.pos_z[COORD_W-1], cand.pos_z})
          - $signed({rec_rdata.pos_z[COORD_W-1], rec_rdata.pos_z});
    dr = {1'b0, cand.bin_row} - {1'b0, rec_rdata.bin_row};
    dc = {1'b0, cand.bin_col} - {1'b0, rec_rdata.bin_col};
  end
  always_ff @(posedge clk) begin
    adx <= ddx[COORD_W] ? (COORD_W+1)'(0) - ddx : ddx;
    ady <= ddy[COORD_W] ? (COORD_W+1)'(0) - ddy : ddy;
    adz <= ddz[COORD_W] ? (COORD_W+1)'(0) - ddz : ddz;
    adj_ok <= (dr == '0 || dr == (BIN_W+1)'(1) || dr == '1)
           && (dc == '0 || dc == (BIN_W+1)'(1) || dc == '1);
    flg_ok <= flg_rdata.loaded && !flg_rdata.unusable && !flg_rdata.killed
           && (cmp_n[AW-1:0] != AW'(q_idx));
    cls_ok <= (rec_rdata.urban_class & urban_mask) != '0;
    di_ok <= rec_rdata.dindex >= dindex_high_cutoff;
    s1_v <= (state == S_SCAN) && cmp_v;
  end

  // stage 2: squares
  logic [2*COORD_W+1:0] sqx, sqy;
  logic s2_ok, s2_v;
  always_ff @(posedge clk) begin
    sqx <= (2*COORD_W+2)'(adx[COORD_W-1:0]) * (2*COORD_W+2)'(adx[COORD_W-1:0]);
    sqy <= (2*COORD_W+2)'(ady[COORD_W-1:0]) * (2*COORD_W+2)'(ady[COORD_W-1:0]);
    s2_ok <= adj_ok && flg_ok && cls_ok && di_ok
          && adx <= (COORD_W+1)'(search_radius) && ady <= (COORD_W+1)'(search_radius)
          && {adz, 1'b0} < (COORD_W+2)'(slab_height);
    s2_v <= s1_v && (state == S_SCAN);
  end
  logic [2*COORD_W+1:0] rsq;
  always_ff @(posedge clk) rsq <= (2*COORD_W+2)'(search_radius) * (2*COORD_W+2)'(search_radius);
  logic match;
  assign match = s2_v && s2_ok && (sqx + sqy <= rsq);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      rsp.valid <= 1'b0;
      cmp_v <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == (AW+1)'(MAX_POINTS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (req.valid && req.ready) begin
          q_idx <= req.data.point_index;
          hit <= 1'b0;
          if (req.data.req_type == REQ_QUERY) begin
            state <= in_range ? S_CRD : S_OUT;
          end
        end
        S_CRD: state <= S_CCHK;
        S_CCHK: begin
          cand <= rec_rdata;
          cnt <= '0;
          cmp_v <= 1'b0;
          if (flg_rdata.loaded && !flg_rdata.unusable && !flg_rdata.killed
              && rec_rdata.dindex < dindex_low_cutoff) state <= S_SCAN;
          else state <= S_OUT;
        end
        S_SCAN: begin
          cmp_n <= cnt;
          cmp_v <= cnt < (AW+1)'(MAX_POINTS);
          if (cnt < (AW+1)'(MAX_POINTS)) cnt <= cnt + 1'b1;
          if (match) begin
            hit <= 1'b1;
            state <= S_KILL;
          end else if (!cmp_v && !s1_v && !s2_v && cnt == (AW+1)'(MAX_POINTS)) begin
            state <= S_OUT;
          end
        end
        S_KILL: state <= S_OUT;
        S_OUT: begin
          rsp.valid <= 1'b1;
          rsp.data.result_index <= q_idx;
          rsp.data.killed <= hit;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ram addressing and writes
  always_comb begin
    raddr = (state == S_SCAN) ? cnt[AW-1:0] : AW'(q_idx);
    if (state == S_IDLE) raddr = AW'(req.data.point_index);
    rec_we = (state == S_IDLE) && req.valid && req.ready
          && req.data.req_type == REQ_LOAD && in_range;
    rec_waddr = AW'(req.data.point_index);
    rec_wdata = '{bin_row: req.data.bin_row, bin_col: req.data.bin_col,
                  pos_x: req.data.pos_x, pos_y: req.data.pos_y, pos_z: req.data.pos_z,
                  dindex: req.data.dindex, urban_class: req.data.urban_class};
    flg_we = rec_we || state == S_CLEAR || state == S_KILL;
    flg_waddr = rec_waddr;
    flg_wdata = '{loaded: 1'b1, unusable: req.data.unusable, killed: 1'b0};
    if (state == S_CLEAR) begin
      flg_waddr = cnt[AW-1:0];
      flg_wdata = '0;
    end else if (state == S_KILL) begin
      flg_waddr = AW'(q_idx);
      flg_wdata = '{loaded: 1'b1, unusable: 1'b0, killed: 1'b1};
    end
  end

`ifndef SYNTH
  a_kill_hit: assert property (@(posedge clk) disable iff (rst)
    state == S_KILL |-> hit) else $error("kill without hit");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> state == S_IDLE) else $error("accept while busy");
  a_rsp_after_out: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |=> rsp.valid) else $error("result lost");
  a_clear_no_req: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !req.ready) else $error("accept during clear");
`endif
endmodule

### verif/tb_top.sv
// tb_top: self-checking bench for neighbor_dindex_point_filter
// depends on ndpf_pkg, ndpf_if and the filter rtl; loads points, queries them and checks kills
`timescale 1ns / 100ps

module tb_top;
  import ndpf_pkg::*;

  localparam int unsigned SLOTS = 1024;
  localparam int unsigned STALL_LIMIT = 8000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  ndpf_req_if req_ch ();
  ndpf_rsp_if rsp_ch ();

  neighbor_dindex_point_filter #(.MAX_POINTS(SLOTS)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  always #1 clk = ~clk;

  // shadow copy of the filter state and its registers
  logic [30:0] radius_q;
  logic [30:0] height_q;
  logic [11:0] dlow_q;
  logic [11:0] dhigh_q;
  logic [7:0] mask_q;
  rec_t shadow_rec [SLOTS];
  flags_t shadow_flg [SLOTS];

  rsp_t expected_kills[$];
  int unsigned mismatch_count = 0;
  bit rsp_idle_on = 1'b1;
  bit req_idle_on = 1'b1;
  bit hold_rsp = 1'b0;

  function automatic logic [32:0] coord_dist(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  function automatic bit bins_near(rec_t a, rec_t b);
    int dr, dc;
    dr = int'(a.bin_row) - int'(b.bin_row);
    dc = int'(a.bin_col) - int'(b.bin_col);
    return (dr >= -1 && dr <= 1 && dc >= -1 && dc <= 1);
  endfunction

  function automatic bit neighbour_kills(int c, int n);
    logic [32:0] dx, dy, dz;
    logic [67:0] dist2, rad2;
    rec_t cr, nr;
    cr = shadow_rec[c];
    nr = shadow_rec[n];
    if (!shadow_flg[n].loaded || shadow_flg[n].unusable || shadow_flg[n].killed) return 0;
    if (!bins_near(cr, nr)) return 0;
    dx = coord_dist(cr.pos_x, nr.pos_x);
    dy = coord_dist(cr.pos_y, nr.pos_y);
    if (dx > 33'(radius_q) || dy > 33'(radius_q)) return 0;
    dist2 = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy);
    rad2 = 68'(radius_q) * 68'(radius_q);
    if (dist2 > rad2) return 0;
    dz = coord_dist(cr.pos_z, nr.pos_z);
    if ({dz, 1'b0} >= 34'(height_q)) return 0;
    if ((nr.urban_class & mask_q) == 8'd0) return 0;
    return nr.dindex >= dhigh_q;
  endfunction

  // apply one accepted request to the shadow state, queue any result
  function automatic void predict_filter(req_t t);
    int c;
    bit hit;
    rsp_t r;
    c = int'(t.point_index);
    hit = 1'b0;
    if (t.req_type == REQ_LOAD) begin
      shadow_rec[c] = '{t.bin_row, t.bin_col, t.pos_x, t.pos_y, t.pos_z, t.dindex,
                        t.urban_class};
      shadow_flg[c] = '{1'b1, t.unusable, 1'b0};
      return;
    end
    if (shadow_flg[c].loaded && !shadow_flg[c].unusable && !shadow_flg[c].killed &&
        shadow_rec[c].dindex < dlow_q) begin
      for (int n = 0; n < SLOTS && !hit; n++)
        if (n != c && neighbour_kills(c, n)) hit = 1'b1;
      if (hit) shadow_flg[c].killed = 1'b1;
    end
    r.result_index = t.point_index;
    r.killed = hit;
    expected_kills.push_back(r);
  endfunction

  // register write, only called while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_RADIUS: radius_q = val;
      REG_HEIGHT: height_q = val;
      REG_DLOW: dlow_q = val[11:0];
      REG_DHIGH: dhigh_q = val[11:0];
      REG_MASK: mask_q = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [30:0] rad, logic [30:0] hgt, logic [11:0] lo,
                            logic [11:0] hi, logic [7:0] msk);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_HEIGHT, hgt);
    write_reg(REG_DLOW, 31'(lo));
    write_reg(REG_DHIGH, 31'(hi));
    write_reg(REG_MASK, 31'(msk));
  endtask

  // send one request transaction
  task automatic send_req(req_t t);
    int gap;
    gap = req_idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= t;
    do @(posedge clk); while (!req_ch.ready);
    predict_filter(t);
  endtask

  task automatic load_pt(int idx, int row, int col, int x, int y, int z, int d, int cls,
                         bit bad);
    req_t t;
    t = '{REQ_LOAD, 10'(idx), 10'(row), 10'(col), 32'(x), 32'(y), 32'(z), 12'(d), 8'(cls),
          bad};
    send_req(t);
  endtask

  task automatic query_pt(int idx);
    req_t t;
    t = '0;
    t.req_type = REQ_QUERY;
    t.point_index = 10'(idx);
    send_req(t);
  endtask

  // wait until every result is in, then let a load settle before a register write
  task automatic drain();
    req_ch.valid <= 1'b0;
    wait (expected_kills.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  // default registers: low cutoff zero means no candidate is ever killed
  task automatic test_reset_defaults();
    load_pt(0, 5, 5, 0, 0, 0, 0, 3, 0);
    load_pt(1, 5, 5, 0, 0, 0, 4095, 3, 0);
    query_pt(0);
    query_pt(1);
    drain();
  endtask

  // hand-built kills, repeats, unusable, unloaded slots, reloads and extremes
  task automatic test_directed_kills();
    set_config(31'd1000, 31'd2000, 12'd100, 12'd3000, 8'd3);
    load_pt(0, 5, 5, 0, 0, 0, 10, 0, 0);
    load_pt(1, 6, 6, 600, 600, 999, 3000, 2, 0);
    query_pt(0);
    query_pt(0);
    load_pt(2, 5, 5, 1000, 0, 0, 50, 1, 0);
    query_pt(2);
    load_pt(3, 9, 9, 0, 0, 0, 5, 0, 0);
    query_pt(3);
    load_pt(4, 5, 5, 0, 0, 0, 5, 0, 1);
    query_pt(4);
    query_pt(1023);
    load_pt(0, 5, 5, 1, 1, -999, 10, 0, 0);
    query_pt(0);
    load_pt(5, 1023, 1023, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 4095, 255, 0);
    load_pt(6, 1023, 1022, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 255, 1);
    load_pt(7, 1022, 1022, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 128, 0);
    query_pt(6);
    query_pt(7);
    drain();
  endtask

  // register extremes: zero radius and height, then widest radius and height with an empty, then a full class mask
  task automatic test_config_extremes();
    set_config(31'd0, 31'd1, 12'd4095, 12'd0, 8'd255);
    load_pt(8, 0, 0, 7, 7, 7, 0, 1, 0);
    load_pt(9, 0, 1, 7, 7, 7, 0, 1, 0);
    load_pt(10, 1, 1, 7, 7, 7, 0, 1, 0);
    query_pt(8);
    query_pt(9);
    drain();
    set_config(31'd0, 31'd0, 12'd4095, 12'd0, 8'd255);
    load_pt(9, 0, 1, 7, 7, 7, 0, 1, 0);
    query_pt(9);
    drain();
    set_config(31'h7fff_ffff, 31'h7fff_ffff, 12'd4095, 12'd0, 8'd0);
    query_pt(10);
    drain();
    set_config(31'h7fff_ffff, 31'h7fff_ffff, 12'd4095, 12'd0, 8'd255);
    query_pt(10);
    query_pt(7);
    drain();
  endtask

  function automatic req_t random_item(int base_x, int rad, int hgt);
    req_t t;
    logic [159:0] raw;
    if ($urandom_range(0, 9) == 0) begin
      // noise: any slot, any field
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      t = raw[$bits(req_t)-1:0];
      return t;
    end
    t = '0;
    t.req_type = ($urandom_range(0, 9) < 6) ? REQ_LOAD : REQ_QUERY;
    t.point_index = 10'($urandom_range(0, 47));
    t.bin_row = 10'($urandom_range(10, 13));
    t.bin_col = 10'($urandom_range(10, 13));
    t.pos_x = 32'(base_x + $urandom_range(0, 2 * rad));
    t.pos_y = 32'(-base_x + $urandom_range(0, 2 * rad));
    t.pos_z = 32'($urandom_range(0, hgt) - hgt / 2);
    t.dindex = 12'($urandom_range(0, 4095));
    t.urban_class = 8'($urandom);
    t.unusable = ($urandom_range(0, 7) == 0);
    return t;
  endfunction

  task automatic test_random(int count, int base_x, int rad, int hgt);
    for (int i = 0; i < count; i++) begin
      if (i % 80 == 0) begin
        req_idle_on = $urandom_range(0, 1);
        rsp_idle_on = $urandom_range(0, 1);
      end
      send_req(random_item(base_x, rad, hgt));
    end
    req_idle_on = 1'b1;
    rsp_idle_on = 1'b1;
    drain();
  endtask

  // receiver stalls a long stretch while queries keep coming, then the sender waits
  task automatic test_backpressure();
    set_config(31'd1000, 31'd2000, 12'd100, 12'd3000, 8'd3);
    hold_rsp = 1'b1;
    req_idle_on = 1'b0;
    for (int i = 0; i < 12; i++) query_pt(i % 4 == 0 ? 2 : 3);
    req_idle_on = 1'b1;
    drain();
  endtask

  // result receiver with random stalls
  initial begin
    int gap;
    rsp_ch.ready = 1'b0;
    forever begin
      if (hold_rsp) begin
        gap = HOLD_CYCLES;
        hold_rsp = 1'b0;
      end else begin
        gap = rsp_idle_on ? $urandom_range(0, 8) : 0;
      end
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && !rst));
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_kills.size() == 0) begin
        $error("unexpected result: index %0d killed %0d", rsp_ch.data.result_index,
               rsp_ch.data.killed);
        mismatch_count++;
      end else begin
        exp_r = expected_kills.pop_front();
        if (rsp_ch.data.result_index !== exp_r.result_index) begin
          $error("result_index: expected %0d, actual %0d", exp_r.result_index,
                 rsp_ch.data.result_index);
          mismatch_count++;
        end
        if (rsp_ch.data.killed !== exp_r.killed) begin
          $error("killed: expected %0d, actual %0d", exp_r.killed, rsp_ch.data.killed);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    int unsigned quiet;
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("** neighbor_dindex_point_filter: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    radius_q = 31'd1000;
    height_q = 31'd2000;
    dlow_q = 12'd0;
    dhigh_q = 12'd4095;
    mask_q = 8'd3;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_rec[i] = '0;
      shadow_flg[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed_kills();
    test_config_extremes();
    test_backpressure();
    set_config(31'd1000, 31'd2000, 12'd1500, 12'd2500, 8'd3);
    test_random(250, -500, 1000, 2000);
    set_config(31'd3000, 31'd600, 12'd3000, 12'd800, 8'h81);
    test_random(250, 20000, 3000, 1000);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && expected_kills.size() == 0) begin
      $display("** neighbor_dindex_point_filter: PASSED **");
    end else begin
      $display("** neighbor_dindex_point_filter: FAILED **");
    end
    $finish;
  end
endmodule
